@@ rtl/chp_pkg.sv @@
// Shared types, constants and angle tables for the compass heading pipeline.
package chp_pkg;

  localparam int COORD_WIDTH_DEF     = 32;
  localparam int CORDIC_STAGES_DEF   = 20;
  localparam int ANGLE_FRAC_BITS_DEF = 10;

  localparam int HEAD_INT_BITS = 9;
  localparam int QUAD_INT_BITS = 7;

  localparam int NORM_W = 60;
  localparam int XW     = 64;
  localparam int ZW     = 48;
  localparam int ZU     = 47;

  localparam int DEG_QUARTER = 90;
  localparam int DEG_HALF    = 180;
  localparam int DEG_3Q      = 270;
  localparam int DEG_FULL    = 360;

  localparam logic [63:0] DEG_UNIT       = 64'd1000000000000;
  localparam logic [63:0] HALF_UNIT      = 64'd500000000000;
  localparam logic [63:0] QUARTER_E12    = 64'd90000000000000;
  localparam logic [63:0] RAD_IN_DEG_E12 = 64'd57295779513082;

  // The degree unit splits into 2^12 times the odd factor 5^12.
  localparam int          DIV_POW2  = 12;
  localparam int          ODD_SHIFT = 27;
  localparam int          ODD_W     = 28;
  localparam logic [63:0] DIV_ODD   = 64'd244140625;

  localparam int ATAN_LEN = 17;

  localparam logic [63:0] ATAN_TAB [ATAN_LEN] = '{
    64'd45000000000000, 64'd26565051177078, 64'd14036243467926,
    64'd7125016348902,  64'd3576334374997,  64'd1789910608246,
    64'd895173710211,   64'd447614170861,   64'd223810500369,
    64'd111905677066,   64'd55952891894,    64'd27976452617,
    64'd13988227142,    64'd6994113675,     64'd3497056851,
    64'd1748528427,     64'd874264214
  };

  typedef enum logic [1:0] {
    DIR_N,
    DIR_E,
    DIR_S,
    DIR_W
  } axis_dir_t;

  typedef struct packed {
    logic      axis;
    axis_dir_t dir;
    logic      neg_x;
    logic      neg_y;
  } chp_ctl_t;

  function automatic logic [ZW-1:0] stage_angle(input int unsigned i);
    logic [63:0] v;
    if (i < ATAN_LEN) begin
      v = ATAN_TAB[i[4:0]];
    end else begin
      v = (RAD_IN_DEG_E12 + (64'd1 << (i - 1))) >> i;
    end
    return v[ZW-1:0];
  endfunction

endpackage

@@ rtl/chp_cordic.sv @@
// Pipelined CORDIC vectoring unit, one rotation per register stage.
module chp_cordic #(
  parameter int STAGES = chp_pkg::CORDIC_STAGES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           ce,
  input  logic                           in_valid,
  input  logic signed [chp_pkg::XW-1:0]  in_x,
  input  logic signed [chp_pkg::XW-1:0]  in_y,
  input  chp_pkg::chp_ctl_t              in_ctl,
  output logic                           out_valid,
  output logic signed [chp_pkg::ZW-1:0]  out_z,
  output chp_pkg::chp_ctl_t              out_ctl
);
  import chp_pkg::*;

  logic signed [XW-1:0] x_r   [STAGES];
  logic signed [XW-1:0] y_r   [STAGES];
  logic signed [ZW-1:0] z_r   [STAGES];
  logic                 v_r   [STAGES];
  chp_ctl_t             ctl_r [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    localparam logic signed [ZW-1:0] ANG = stage_angle(i);

    logic signed [XW-1:0] xi;
    logic signed [XW-1:0] yi;
    logic signed [ZW-1:0] zi;
    logic                 vi;
    chp_ctl_t             ci;
    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    if (i == 0) begin : g_first
      assign xi = in_x;
      assign yi = in_y;
      assign zi = '0;
      assign vi = in_valid;
      assign ci = in_ctl;
    end else begin : g_next
      assign xi = x_r[i-1];
      assign yi = y_r[i-1];
      assign zi = z_r[i-1];
      assign vi = v_r[i-1];
      assign ci = ctl_r[i-1];
    end

    assign xs = xi >>> i;
    assign ys = yi >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_r[i] <= 1'b0;
      end else if (ce) begin
        v_r[i] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        ctl_r[i] <= ci;
        if (!yi[XW-1]) begin
          x_r[i] <= xi + ys;
          y_r[i] <= yi - xs;
          z_r[i] <= zi + ANG;
        end else begin
          x_r[i] <= xi - ys;
          y_r[i] <= yi + xs;
          z_r[i] <= zi - ANG;
        end
      end
    end
  end

  assign out_valid = v_r[STAGES-1];
  assign out_z     = z_r[STAGES-1];
  assign out_ctl   = ctl_r[STAGES-1];

endmodule

@@ rtl/chp_round.sv @@
// Clamp of the quadrant angle and pipelined rounding division to the output unit.
module chp_round #(
  parameter int FRAC = chp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          ce,
  input  logic                          in_valid,
  input  logic signed [chp_pkg::ZW-1:0] in_z,
  input  chp_pkg::chp_ctl_t             in_ctl,
  output logic                          out_valid,
  output logic [chp_pkg::QUAD_INT_BITS+FRAC-1:0] out_a,
  output chp_pkg::chp_ctl_t             out_ctl
);
  import chp_pkg::*;

  localparam int NW  = ZU + FRAC;
  localparam int QB  = QUAD_INT_BITS + FRAC;
  localparam int PW  = NW - DIV_POW2;
  localparam int TW  = PW - ODD_SHIFT;
  localparam int RS  = TW + 2;
  localparam int PRW = TW + RS;
  localparam int RW  = ODD_W + 1;

  localparam logic [ODD_W-1:0] ODD   = ODD_W'(DIV_ODD);
  localparam logic [RS-1:0]    RECIP = RS'((64'd1 << (RS + ODD_SHIFT)) / DIV_ODD);

  logic [ZW-1:0] zu;
  logic [ZU-1:0] zc;
  logic          vc;
  chp_ctl_t      cc;
  logic [PW-1:0] num;
  logic          vn;
  chp_ctl_t      cn;

  logic [QB-1:0] qe1;
  logic [PW-1:0] np1;
  logic          vq1;
  chp_ctl_t      cq1;

  logic [QB-1:0] qe2;
  logic [PW-1:0] np2;
  logic [PW-1:0] qd2;
  logic          vq2;
  chp_ctl_t      cq2;

  logic [QB-1:0] qe3;
  logic [RW-1:0] rem3;
  logic          vq3;
  chp_ctl_t      cq3;

  logic [QB-1:0] q4;
  logic          vq4;
  chp_ctl_t      cq4;

  assign zu = in_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc  <= 1'b0;
      vn  <= 1'b0;
      vq1 <= 1'b0;
      vq2 <= 1'b0;
      vq3 <= 1'b0;
      vq4 <= 1'b0;
    end else if (ce) begin
      vc  <= in_valid;
      vn  <= vc;
      vq1 <= vn;
      vq2 <= vq1;
      vq3 <= vq2;
      vq4 <= vq3;
    end
  end

  // The estimate from the top bits is at most one below the true quotient,
  // so a single compare of the remainder finishes the division.
  always_ff @(posedge clk) begin
    if (ce) begin
      cc <= in_ctl;
      if (in_z[ZW-1]) begin
        zc <= '0;
      end else if (zu > ZW'(QUARTER_E12)) begin
        zc <= ZU'(QUARTER_E12);
      end else begin
        zc <= zu[ZU-1:0];
      end
      cn  <= cc;
      num <= PW'(((NW'(zc) << FRAC) + NW'(HALF_UNIT)) >> DIV_POW2);

      cq1 <= cn;
      np1 <= num;
      qe1 <= QB'((PRW'(num[PW-1 -: TW]) * PRW'(RECIP)) >> RS);

      cq2 <= cq1;
      np2 <= np1;
      qe2 <= qe1;
      qd2 <= PW'(qe1) * PW'(ODD);

      cq3  <= cq2;
      qe3  <= qe2;
      rem3 <= RW'(np2 - qd2);

      cq4 <= cq3;
      q4  <= qe3 + QB'(rem3 >= RW'(ODD));
    end
  end

  assign out_valid = vq4;
  assign out_a     = q4;
  assign out_ctl   = cq4;

endmodule

@@ rtl/compass_heading_from_two_points.sv @@
// Compass heading of the vector from a start point to an end point.
//
// One transfer on the s_ side carries a start point and an end point as signed
// coordinates; one transfer on the m_ side returns the bearing of the vector
// between them, clockwise from the +y axis in 1/2^ANGLE_FRAC_BITS degree.
// Axis directions give exact multiples of 90 degrees and coincident points
// give 0.
// The path is a fixed pipeline: difference, magnitude, larger magnitude, two
// normalising shift stages, one stage per CORDIC rotation, a clamp, a rounding
// offset, four stages of reciprocal multiplication with one correction step for
// the rounding division and a final quadrant stage. A new transfer is accepted
// in every cycle while the output is not held back, since each CORDIC stage does
// one rotation.
// The whole pipeline advances together; when m_tready is low while a result is
// held, s_tready drops and every stage holds, so nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
module compass_heading_from_two_points #(
  parameter int COORD_WIDTH     = chp_pkg::COORD_WIDTH_DEF,
  parameter int CORDIC_STAGES   = chp_pkg::CORDIC_STAGES_DEF,
  parameter int ANGLE_FRAC_BITS = chp_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // start_x, start_y, end_x, end_y
  input  logic [((4*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
  output logic m_tvalid,
  input  logic m_tready,
  // heading
  output logic [((chp_pkg::HEAD_INT_BITS+ANGLE_FRAC_BITS+7)/8)*8-1:0] m_tdata
);
  import chp_pkg::*;

  localparam int CW     = COORD_WIDTH;
  localparam int OW     = HEAD_INT_BITS + ANGLE_FRAC_BITS;
  localparam int OUT_TW = ((OW + 7) / 8) * 8;
  localparam int QB     = QUAD_INT_BITS + ANGLE_FRAC_BITS;

  localparam logic [OW-1:0] H_QTR  = OW'(DEG_QUARTER) << ANGLE_FRAC_BITS;
  localparam logic [OW-1:0] H_HALF = OW'(DEG_HALF) << ANGLE_FRAC_BITS;
  localparam logic [OW-1:0] H_3Q   = OW'(DEG_3Q) << ANGLE_FRAC_BITS;
  localparam logic [OW-1:0] H_FULL = OW'(DEG_FULL) << ANGLE_FRAC_BITS;

  logic ce;

  logic [CW-1:0] start_x, start_y, end_x, end_y;

  logic              v1;
  logic signed [CW:0] dx, dy;

  logic          v2;
  logic [CW:0]   ax, ay;
  chp_ctl_t      ctl2;

  logic              v3;
  logic [NORM_W-1:0] n3, d3, m3;
  chp_ctl_t          ctl3;

  logic              v4;
  logic [NORM_W-1:0] n4, d4, m4;
  chp_ctl_t          ctl4;

  logic              v5;
  logic [NORM_W-1:0] n5, d5;
  chp_ctl_t          ctl5;

  logic [NORM_W-1:0] n4_next, d4_next, m4_next;
  logic [NORM_W-1:0] n5_next, d5_next, m5_next;

  logic                 cor_valid;
  logic signed [ZW-1:0] cor_z;
  chp_ctl_t             cor_ctl;

  logic          rnd_valid;
  logic [QB-1:0] rnd_a;
  chp_ctl_t      rnd_ctl;

  logic [OW-1:0] a_ext;
  logic [OW-1:0] h_raw;
  logic [OW-1:0] h_next;
  logic [OW-1:0] heading;

  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  assign start_x = s_tdata[CW-1:0];
  assign start_y = s_tdata[2*CW-1:CW];
  assign end_x   = s_tdata[3*CW-1:2*CW];
  assign end_y   = s_tdata[4*CW-1:3*CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1       <= 1'b0;
      v2       <= 1'b0;
      v3       <= 1'b0;
      v4       <= 1'b0;
      v5       <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (ce) begin
      v1       <= s_tvalid;
      v2       <= v1;
      v3       <= v2;
      v4       <= v3;
      v5       <= v4;
      m_tvalid <= rnd_valid;
    end
  end

  always_comb begin
    n4_next = n3;
    d4_next = d3;
    m4_next = m3;
    for (int s = 0; s < 3; s++) begin
      if ((m4_next >> (NORM_W - (32 >> s))) == '0) begin
        m4_next = m4_next << (32 >> s);
        n4_next = n4_next << (32 >> s);
        d4_next = d4_next << (32 >> s);
      end
    end
  end

  always_comb begin
    n5_next = n4;
    d5_next = d4;
    m5_next = m4;
    for (int s = 0; s < 3; s++) begin
      if ((m5_next >> (NORM_W - (4 >> s))) == '0) begin
        m5_next = m5_next << (4 >> s);
        n5_next = n5_next << (4 >> s);
        d5_next = d5_next << (4 >> s);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      dx <= $signed({end_x[CW-1], end_x}) - $signed({start_x[CW-1], start_x});
      dy <= $signed({end_y[CW-1], end_y}) - $signed({start_y[CW-1], start_y});

      ax <= dx[CW] ? $unsigned(-dx) : $unsigned(dx);
      ay <= dy[CW] ? $unsigned(-dy) : $unsigned(dy);
      ctl2.axis  <= (dx == '0) || (dy == '0);
      ctl2.neg_x <= dx[CW];
      ctl2.neg_y <= dy[CW];
      if (dx == '0) begin
        ctl2.dir <= dy[CW] ? DIR_S : DIR_N;
      end else begin
        ctl2.dir <= dx[CW] ? DIR_W : DIR_E;
      end

      n3   <= NORM_W'(ax);
      d3   <= NORM_W'(ay);
      m3   <= (ax > ay) ? NORM_W'(ax) : NORM_W'(ay);
      ctl3 <= ctl2;

      n4   <= n4_next;
      d4   <= d4_next;
      m4   <= m4_next;
      ctl4 <= ctl3;

      n5   <= n5_next;
      d5   <= d5_next;
      ctl5 <= ctl4;
    end
  end

  chp_cordic #(
    .STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (v5),
    .in_x      (signed'(XW'(d5))),
    .in_y      (signed'(XW'(n5))),
    .in_ctl    (ctl5),
    .out_valid (cor_valid),
    .out_z     (cor_z),
    .out_ctl   (cor_ctl)
  );

  chp_round #(
    .FRAC (ANGLE_FRAC_BITS)
  ) u_round (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .in_valid  (cor_valid),
    .in_z      (cor_z),
    .in_ctl    (cor_ctl),
    .out_valid (rnd_valid),
    .out_a     (rnd_a),
    .out_ctl   (rnd_ctl)
  );

  assign a_ext = OW'(rnd_a);

  always_comb begin
    if (rnd_ctl.axis) begin
      unique case (rnd_ctl.dir)
        DIR_N:   h_raw = '0;
        DIR_E:   h_raw = H_QTR;
        DIR_S:   h_raw = H_HALF;
        DIR_W:   h_raw = H_3Q;
        default: h_raw = '0;
      endcase
    end else if (!rnd_ctl.neg_x && !rnd_ctl.neg_y) begin
      h_raw = a_ext;
    end else if (rnd_ctl.neg_x && !rnd_ctl.neg_y) begin
      h_raw = H_FULL - a_ext;
    end else if (!rnd_ctl.neg_x) begin
      h_raw = H_HALF - a_ext;
    end else begin
      h_raw = H_HALF + a_ext;
    end
    h_next = (h_raw >= H_FULL) ? '0 : h_raw;
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      heading <= h_next;
    end
  end

  assign m_tdata = OUT_TW'(heading);

endmodule
